>>> rtl/bpa_pkg.sv
package bpa_pkg;

    // fixed field widths
    localparam int PAGE_W  = 15;
    localparam int OFF_W   = 32;
    localparam int DATA_W  = 32;
    localparam int APB_AW  = 4;

    // register reset values
    localparam logic [PAGE_W-1:0] INIT_PAGES_RST = 15'd1024;
    localparam logic [PAGE_W-1:0] GROW_STEP_RST  = 15'd16;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOSPACE    = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_RANGE      = 3'd3,
        ST_NOTUSED    = 3'd4
    } t_status;

    // register indexes (word address)
    typedef enum logic [1:0] {
        REG_FIXED = 2'd0,
        REG_INIT  = 2'd1,
        REG_STEP  = 2'd2
    } t_reg_idx;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_GROW_RD,
        S_TAKE,
        S_FREE_RD,
        S_FREE_EV,
        S_DONE
    } t_state;

    // configuration seen by the datapath
    typedef struct packed {
        logic              fixed_mode;
        logic [PAGE_W-1:0] grow_step;
        logic [PAGE_W-1:0] init_new;
        logic              reinit;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic    clr_step;
        logic    scan_init;
        logic    scan_restart;
        logic    scan_next;
        logic    free_setup;
        logic    grow_apply;
        logic    rd_en;
        logic    take;
        logic    take_scan_bit;
        logic    release_pg;
        logic    set_res;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic alloc_blocked;
        logic cur_in_pool;
        logic next_in_pool;
        logic byte_hit;
        logic restarted;
        logic free_nz;
        logic fixed_mode;
        logic grow_ok;
        logic misaligned;
        logic out_of_range;
        logic bit_used;
        logic can_load;
    } t_stat;

endpackage

>>> rtl/bpa_req_if.sv
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] page_offset;

    modport source (output valid, output func, output page_offset, input ready);
    modport sink   (input valid, input func, input page_offset, output ready);
endinterface

>>> rtl/bpa_rsp_if.sv
interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [14:0] page_index;
    logic [14:0] free_pages;

    modport source (output valid, output status, output page_index, output free_pages,
                    input ready);
    modport sink   (input valid, input status, input page_index, input free_pages,
                    output ready);
endinterface

>>> rtl/bpa_regs.sv
module bpa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::APB_AW-1:0]    paddr,
    input  logic [bpa_pkg::DATA_W-1:0]    pwdata,
    output logic [bpa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output bpa_pkg::t_cfg                 o_cfg
);
    import bpa_pkg::*;

    logic              r_fixed;
    logic [PAGE_W-1:0] r_init;
    logic [PAGE_W-1:0] r_step;
    logic              w_wr;
    t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed <= 1'b0;
            r_init  <= INIT_PAGES_RST;
            r_step  <= GROW_STEP_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_FIXED: r_fixed <= pwdata[0];
                REG_INIT:  r_init  <= pwdata[PAGE_W-1:0];
                REG_STEP:  r_step  <= pwdata[PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_FIXED: prdata = DATA_W'(r_fixed);
            REG_INIT:  prdata = DATA_W'(r_init);
            REG_STEP:  prdata = DATA_W'(r_step);
            default:   prdata = '0;
        endcase
    end

    // new page count goes straight to the pool on the write edge
    assign o_cfg.fixed_mode = r_fixed;
    assign o_cfg.grow_step  = r_step;
    assign o_cfg.init_new   = pwdata[PAGE_W-1:0];
    assign o_cfg.reinit     = w_wr && (w_idx == REG_INIT);

endmodule

>>> rtl/bpa_ctrl.sv
module bpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_func,
    input  logic           i_reinit,
    input  bpa_pkg::t_stat i_st,
    output logic           o_req_ready,
    output bpa_pkg::t_cmd  o_cmd
);
    import bpa_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   w_end_cmd;
    t_state w_end_state;
    logic   w_restarted;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // what to do when a scan runs off the end of the pool
    assign w_restarted = (r_state == S_IDLE) ? 1'b0 : i_st.restarted;

    always_comb begin
        w_end_cmd   = '0;
        w_end_state = S_DONE;
        if (!w_restarted && i_st.free_nz) begin
            w_end_cmd.scan_restart = 1'b1;
            w_end_state            = S_SCAN_RD;
        end else if (i_st.free_nz || i_st.fixed_mode || !i_st.grow_ok) begin
            w_end_cmd.set_res  = 1'b1;
            w_end_cmd.res_code = ST_NOSPACE;
        end else begin
            w_end_cmd.grow_apply = 1'b1;
            w_end_state          = S_GROW_RD;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = (r_state == S_IDLE) && !i_reinit;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid && !i_reinit) begin
                    if (!i_req_func) begin
                        if (i_st.alloc_blocked) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_NOSPACE;
                            n_state        = S_DONE;
                        end else if (i_st.cur_in_pool) begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN_RD;
                        end else begin
                            o_cmd           = w_end_cmd;
                            o_cmd.scan_init = 1'b1;
                            n_state         = w_end_state;
                        end
                    end else if (i_st.misaligned) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_MISALIGNED;
                        n_state        = S_DONE;
                    end else if (i_st.out_of_range) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = ST_RANGE;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.free_setup = 1'b1;
                        n_state          = S_FREE_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (i_st.byte_hit) begin
                    o_cmd.take          = 1'b1;
                    o_cmd.take_scan_bit = 1'b1;
                    o_cmd.set_res       = 1'b1;
                    o_cmd.res_code      = ST_OK;
                    n_state             = S_DONE;
                end else if (i_st.next_in_pool) begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN_RD;
                end else begin
                    o_cmd   = w_end_cmd;
                    n_state = w_end_state;
                end
            end
            S_GROW_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take     = 1'b1;
                o_cmd.set_res  = 1'b1;
                o_cmd.res_code = ST_OK;
                n_state        = S_DONE;
            end
            S_FREE_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_FREE_EV;
            end
            S_FREE_EV: begin
                o_cmd.set_res = 1'b1;
                if (i_st.bit_used) begin
                    o_cmd.release_pg = 1'b1;
                    o_cmd.res_code   = ST_OK;
                end else begin
                    o_cmd.res_code = ST_NOTUSED;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.can_load) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // pool reinit always restarts the clearing pass
        if (i_reinit) begin
            n_state = S_CLEAR;
        end
    end

endmodule

>>> rtl/bpa_dp.sv
module bpa_dp #(
    parameter int BITMAP_BYTES = 4096,
    parameter int MAX_PAGES    = 32767,
    parameter int PAGE_SHIFT   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpa_pkg::t_cfg                 i_cfg,
    input  bpa_pkg::t_cmd                 i_cmd,
    input  logic [bpa_pkg::OFF_W-1:0]     i_req_offset,
    input  logic                          i_rsp_ready,
    output bpa_pkg::t_stat                o_st,
    output logic                          o_rsp_valid,
    output logic [2:0]                    o_rsp_status,
    output logic [bpa_pkg::PAGE_W-1:0]    o_rsp_page,
    output logic [bpa_pkg::PAGE_W-1:0]    o_rsp_free
);
    import bpa_pkg::*;

    localparam int BYTE_W   = $clog2(BITMAP_BYTES);
    localparam int POOL_CAP = (MAX_PAGES < 8 * BITMAP_BYTES) ? MAX_PAGES : 8 * BITMAP_BYTES;
    localparam logic [PAGE_W-1:0] CAP = PAGE_W'(POOL_CAP);
    localparam logic [PAGE_W-1:0] RST_PAGES = (INIT_PAGES_RST > CAP) ? CAP : INIT_PAGES_RST;

    logic [7:0]        r_mem [BITMAP_BYTES];
    logic [7:0]        r_rd;
    logic [BYTE_W-1:0] r_byte;
    logic [2:0]        r_bit;
    logic [BYTE_W-1:0] r_cursor;
    logic              r_restart;
    logic [PAGE_W-1:0] r_free;
    logic [PAGE_W-1:0] r_total;
    logic [BYTE_W-1:0] r_clr;
    t_status           r_res_status;
    logic [PAGE_W-1:0] r_res_page;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [PAGE_W-1:0] r_out_page;
    logic [PAGE_W-1:0] r_out_free;

    logic [PAGE_W-1:0] w_init;
    logic [PAGE_W-1:0] w_room;
    logic [PAGE_W-1:0] w_inc;
    logic [BYTE_W:0]   w_byte_nx;
    logic [7:0]        w_mask;
    logic [7:0]        w_eff;
    logic [2:0]        w_low;
    logic [2:0]        w_tbit;
    logic [7:0]        w_onehot;
    logic              w_we;
    logic [BYTE_W-1:0] w_wa;
    logic [7:0]        w_wd;

    // capped pool size for a reinit and for growth
    assign w_init = (i_cfg.init_new > CAP) ? CAP : i_cfg.init_new;
    assign w_room = CAP - r_total;
    assign w_inc  = (i_cfg.grow_step > w_room) ? w_room : i_cfg.grow_step;

    // bits past the end of the pool look used
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_mask[i] = 16'({r_byte, 3'(i)}) >= {1'b0, r_total};
        end
    end
    assign w_eff = r_rd | w_mask;

    // lowest clear bit of the byte just read
    always_comb begin
        w_low = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!w_eff[i]) begin
                w_low = 3'(i);
            end
        end
    end

    assign w_tbit    = i_cmd.take_scan_bit ? w_low : r_bit;
    assign w_onehot  = 8'b1 << w_tbit;
    assign w_byte_nx = {1'b0, r_byte} + (BYTE_W + 1)'(1);

    // status to the controller
    assign o_st.clr_last      = (r_clr == BYTE_W'(BITMAP_BYTES - 1));
    assign o_st.alloc_blocked = (r_free == '0) && (i_cfg.fixed_mode || r_total >= CAP);
    assign o_st.cur_in_pool   = 16'({r_cursor, 3'b000}) < {1'b0, r_total};
    assign o_st.next_in_pool  = (w_byte_nx < (BYTE_W + 1)'(BITMAP_BYTES))
                              && (16'({w_byte_nx, 3'b000}) < {1'b0, r_total});
    assign o_st.byte_hit      = (w_eff != 8'hFF);
    assign o_st.restarted     = r_restart;
    assign o_st.free_nz       = (r_free != '0);
    assign o_st.fixed_mode    = i_cfg.fixed_mode;
    assign o_st.grow_ok       = (w_inc != '0);
    assign o_st.misaligned    = (i_req_offset[PAGE_SHIFT-1:0] != '0);
    assign o_st.out_of_range  = (i_req_offset >> PAGE_SHIFT) >= OFF_W'(r_total);
    assign o_st.bit_used      = ((r_rd & w_onehot) != 8'h00);
    assign o_st.can_load      = !r_out_valid || i_rsp_ready;

    // bitmap memory port
    assign w_we = i_cmd.clr_step || i_cmd.take || i_cmd.release_pg;
    assign w_wa = i_cmd.clr_step ? r_clr : r_byte;
    always_comb begin
        if (i_cmd.clr_step) begin
            w_wd = 8'h00;
        end else if (i_cmd.take) begin
            w_wd = r_rd | w_onehot;
        end else begin
            w_wd = r_rd & ~w_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_byte];
        end
    end

    // scan pointers, counters and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_restart   <= 1'b0;
            r_free      <= RST_PAGES;
            r_total     <= RST_PAGES;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.reinit) begin
                r_cursor <= '0;
                r_free   <= w_init;
                r_total  <= w_init;
                r_clr    <= '0;
            end else begin
                if (i_cmd.clr_step) begin
                    r_clr <= r_clr + BYTE_W'(1);
                end
                if (i_cmd.scan_init) begin
                    r_byte    <= r_cursor;
                    r_restart <= 1'b0;
                end
                if (i_cmd.scan_restart) begin
                    r_byte    <= '0;
                    r_cursor  <= '0;
                    r_restart <= 1'b1;
                end
                if (i_cmd.scan_next) begin
                    r_byte <= w_byte_nx[BYTE_W-1:0];
                end
                if (i_cmd.free_setup) begin
                    r_byte <= BYTE_W'(i_req_offset >> (PAGE_SHIFT + 3));
                    r_bit  <= 3'(i_req_offset >> PAGE_SHIFT);
                end
                if (i_cmd.grow_apply) begin
                    r_total <= r_total + w_inc;
                    r_free  <= r_free + w_inc;
                    r_byte  <= r_total[BYTE_W+2:3];
                    r_bit   <= r_total[2:0];
                end
                if (i_cmd.take) begin
                    if (r_free != '0) begin
                        r_free <= r_free - PAGE_W'(1);
                    end
                    r_cursor   <= r_byte;
                    r_res_page <= PAGE_W'({r_byte, w_tbit});
                end
                if (i_cmd.release_pg) begin
                    r_free     <= r_free + PAGE_W'(1);
                    r_res_page <= PAGE_W'({r_byte, r_bit});
                end
                if (i_cmd.set_res) begin
                    r_res_status <= i_cmd.res_code;
                    if (i_cmd.res_code != ST_OK) begin
                        r_res_page <= '0;
                    end
                end
            end
            // output register
            if (i_cmd.out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_page   <= r_res_page;
                r_out_free   <= r_free;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp_status = r_out_status;
    assign o_rsp_page   = r_out_page;
    assign o_rsp_free   = r_out_free;

endmodule

>>> rtl/bitmap_page_allocator_top.sv
// channel   | dir | handshake   | payload
// ----------+-----+-------------+---------------------------------------
// i_req     | in  | valid/ready | func, page_offset
// o_rsp     | out | valid/ready | status, page_index, free_pages
// apb cfg   | in  | psel/penable| fixed_pool_mode, initial_pages, grow_step
//
// allocate: reads and checks the bitmap a byte at a time, starting at the cursor;
//   growth, when allowed, adds pages and takes the first new one
// free: reads the page's byte, then clears its bit; bad requests answer without a read
// reset and each initial_pages write run a clearing pass over all BITMAP_BYTES bytes
//   with i_req.ready low
// one item at a time; a finished result waits in the output register while the
//   next item is taken, and the block holds when that register is still full
module bitmap_page_allocator_top #(
    parameter int BITMAP_BYTES = 4096,
    parameter int MAX_PAGES    = 32767,
    parameter int PAGE_SHIFT   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpa_req_if.sink                       i_req,
    bpa_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpa_pkg::APB_AW-1:0]    paddr,
    input  logic [bpa_pkg::DATA_W-1:0]    pwdata,
    output logic [bpa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import bpa_pkg::*;

    localparam int POOL_CAP = (MAX_PAGES < 8 * BITMAP_BYTES) ? MAX_PAGES : 8 * BITMAP_BYTES;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_st;

    // configuration registers
    bpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer
    bpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .i_reinit    (w_cfg.reinit),
        .i_st        (w_st),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd)
    );

    // bitmap, counters and output register
    bpa_dp #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .MAX_PAGES    (MAX_PAGES),
        .PAGE_SHIFT   (PAGE_SHIFT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .i_req_offset (i_req.page_offset),
        .i_rsp_ready  (o_rsp.ready),
        .o_st         (w_st),
        .o_rsp_valid  (o_rsp.valid),
        .o_rsp_status (o_rsp.status),
        .o_rsp_page   (o_rsp.page_index),
        .o_rsp_free   (o_rsp.free_pages)
    );

    // an accepted item keeps the block busy on the next cycle
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("input ready right after an accepted item");

    // failed requests carry page zero
    a_fail_page_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.page_index == '0))
        else $error("nonzero page on a failed request");

    // free count never passes the pool capacity
    a_free_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.free_pages <= PAGE_W'(POOL_CAP)))
        else $error("free count above capacity");

endmodule
